/* hdl/b2w_pkg.sv */
// Shared types, constants and helper functions for the BLAKE2b work check core.
// Holds the IV, the message schedule table and the register index codes.
// No dependencies.
`default_nettype none

package b2w_pkg;

    typedef logic [63:0]        b2w_word_t;
    typedef logic [15:0][63:0]  b2w_vec_t;
    typedef logic [3:0][63:0]   b2w_words_t;

    // Compression geometry: 12 rounds, each two layers of four G lanes,
    // each layer cut into four add/xor/rotate steps.
    localparam int unsigned B2W_ROUNDS          = 12;
    localparam int unsigned B2W_STEPS_PER_ROUND = 8;
    localparam int unsigned B2W_STEPS           = B2W_ROUNDS * B2W_STEPS_PER_ROUND;

    // Configuration register indexes
    localparam int unsigned B2W_CFG_IDX_W       = 3;
    localparam logic [B2W_CFG_IDX_W-1:0] B2W_REG_HASH0  = 3'd0;
    localparam logic [B2W_CFG_IDX_W-1:0] B2W_REG_HASH1  = 3'd1;
    localparam logic [B2W_CFG_IDX_W-1:0] B2W_REG_HASH2  = 3'd2;
    localparam logic [B2W_CFG_IDX_W-1:0] B2W_REG_HASH3  = 3'd3;
    localparam logic [B2W_CFG_IDX_W-1:0] B2W_REG_THRESH = 3'd4;

    // IV
    localparam b2w_word_t B2W_IV0 = 64'h6a09e667f3bcc908;
    localparam b2w_word_t B2W_IV1 = 64'hbb67ae8584caa73b;
    localparam b2w_word_t B2W_IV2 = 64'h3c6ef372fe94f82b;
    localparam b2w_word_t B2W_IV3 = 64'ha54ff53a5f1d36f1;
    localparam b2w_word_t B2W_IV4 = 64'h510e527fade682d1;
    localparam b2w_word_t B2W_IV5 = 64'h9b05688c2b3e6c1f;
    localparam b2w_word_t B2W_IV6 = 64'h1f83d9abfb41bd6b;
    localparam b2w_word_t B2W_IV7 = 64'h5be0cd19137e2179;

    // Chaining word 0 with digest length 8, fanout 1, depth 1 folded in
    localparam b2w_word_t B2W_H0        = 64'h6a09e667f2bdc900;
    // IV4 with the 40-byte counter folded in, IV6 with the final flag folded in
    localparam b2w_word_t B2W_V12_INIT  = 64'h510e527fade682f9;
    localparam b2w_word_t B2W_V14_INIT  = 64'he07c265404be4294;

    // Working vector at the start of the single compression
    function automatic b2w_vec_t b2w_init_vec();
        b2w_vec_t v;
        v[0]  = B2W_H0;
        v[1]  = B2W_IV1;
        v[2]  = B2W_IV2;
        v[3]  = B2W_IV3;
        v[4]  = B2W_IV4;
        v[5]  = B2W_IV5;
        v[6]  = B2W_IV6;
        v[7]  = B2W_IV7;
        v[8]  = B2W_IV0;
        v[9]  = B2W_IV1;
        v[10] = B2W_IV2;
        v[11] = B2W_IV3;
        v[12] = B2W_V12_INIT;
        v[13] = B2W_IV5;
        v[14] = B2W_V14_INIT;
        v[15] = B2W_IV7;
        return v;
    endfunction

    // Message schedule: nibble p of the row is the word index used at position p
    function automatic logic [3:0] b2w_sigma(input logic [3:0] rnd, input logic [3:0] pos);
        logic [63:0] row;
        case (rnd)
            4'd0:    row = 64'hfedcba9876543210;
            4'd1:    row = 64'h357b20c16df984ae;
            4'd2:    row = 64'h491763eadf250c8b;
            4'd3:    row = 64'h8f04a562ebcd1397;
            4'd4:    row = 64'hd386cb1efa427509;
            4'd5:    row = 64'h91ef57d438b0a6c2;
            4'd6:    row = 64'hb8293670a4def15c;
            4'd7:    row = 64'ha2684f05931ce7bd;
            4'd8:    row = 64'h5a417d2c803b9ef6;
            4'd9:    row = 64'h0dc3e9bf5167482a;
            4'd10:   row = 64'hfedcba9876543210;
            4'd11:   row = 64'h357b20c16df984ae;
            default: row = 64'hfedcba9876543210;
        endcase
        return row[{pos, 2'b00} +: 4];
    endfunction

    // Message word by index: word 0 is the nonce, 1..4 the block hash, rest zero
    function automatic b2w_word_t b2w_msg(input logic [3:0] idx, input b2w_word_t nonce,
                                          input b2w_words_t hash_words);
        b2w_word_t w;
        case (idx)
            4'd0:    w = nonce;
            4'd1:    w = hash_words[0];
            4'd2:    w = hash_words[1];
            4'd3:    w = hash_words[2];
            4'd4:    w = hash_words[3];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/b2w_if.sv */
// Valid/ready channel interfaces for the BLAKE2b work check core.
// Depends on nothing; one interface per direction of word flow.
`default_nettype none

interface b2w_nonce_if;
    logic        valid;
    logic        ready;
    logic [63:0] nonce;

    modport source (output valid, output nonce, input ready);
    modport sink   (input valid, input nonce, output ready);
endinterface

interface b2w_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] nonce_out;
    logic [63:0] digest;
    logic        meets_threshold;

    modport source (output valid, output nonce_out, output digest,
                    output meets_threshold, input ready);
    modport sink   (input valid, input nonce_out, input digest,
                    input meets_threshold, output ready);
endinterface

`default_nettype wire

/* hdl/blake2b_work_threshold_check_core.sv */
// BLAKE2b work check core: 96 compression steps, then digest and threshold compare.
// Each nonce word passes through the step registers in order, then the output register.
// Throughput: one nonce per cycle; the whole pipeline holds when a result stalls.
// Reset: async active low; clears valid bits and config registers (all zero).
// Depends on b2w_pkg, b2w_if and b2w_mix_step.
`default_nettype none

module blake2b_work_threshold_check_core
    import b2w_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [B2W_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]              cfg_data,
    b2w_nonce_if.sink                     nonce_ch,
    b2w_result_if.source                  result_ch
);

    b2w_words_t hash_words_reg;
    b2w_word_t  thresh_reg;

    logic                   adv;
    logic [B2W_STEPS:0]     stg_valid;
    b2w_vec_t               stg_v     [B2W_STEPS+1];
    b2w_word_t              stg_nonce [B2W_STEPS+1];

    b2w_word_t digest_next;
    logic      meets_next;

    logic      out_valid_reg;
    b2w_word_t out_nonce_reg;
    b2w_word_t out_digest_reg;
    logic      out_meets_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_words_reg <= '0;
            thresh_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                B2W_REG_HASH0:  hash_words_reg[0] <= cfg_data;
                B2W_REG_HASH1:  hash_words_reg[1] <= cfg_data;
                B2W_REG_HASH2:  hash_words_reg[2] <= cfg_data;
                B2W_REG_HASH3:  hash_words_reg[3] <= cfg_data;
                B2W_REG_THRESH: thresh_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output register is free or drained
    assign adv            = !out_valid_reg || result_ch.ready;
    assign nonce_ch.ready = adv;

    assign stg_valid[0] = nonce_ch.valid;
    assign stg_v[0]     = b2w_init_vec();
    assign stg_nonce[0] = nonce_ch.nonce;

    // Compression steps
    for (genvar s = 0; s < B2W_STEPS; s++) begin : g_step
        b2w_mix_step #(
            .STEP (s)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .valid_in   (stg_valid[s]),
            .v_in       (stg_v[s]),
            .nonce_in   (stg_nonce[s]),
            .hash_words (hash_words_reg),
            .valid_out  (stg_valid[s+1]),
            .v_out      (stg_v[s+1]),
            .nonce_out  (stg_nonce[s+1])
        );
    end

    // Feed-forward of word 0 and the threshold compare
    assign digest_next = B2W_H0 ^ stg_v[B2W_STEPS][0] ^ stg_v[B2W_STEPS][8];
    assign meets_next  = (digest_next >= thresh_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= stg_valid[B2W_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_nonce_reg  <= stg_nonce[B2W_STEPS];
            out_digest_reg <= digest_next;
            out_meets_reg  <= meets_next;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.nonce_out       = out_nonce_reg;
    assign result_ch.digest          = out_digest_reg;
    assign result_ch.meets_threshold = out_meets_reg;

endmodule

`default_nettype wire

/* hdl/b2w_mix_step.sv */
// One registered step of the BLAKE2b round: four G lanes each do one add,
// xor and rotate. Position in the round comes from STEP. Uses b2w_pkg.
`default_nettype none

module b2w_mix_step
    import b2w_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       valid_in,
    input  wire b2w_vec_t   v_in,
    input  wire b2w_word_t  nonce_in,
    input  wire b2w_words_t hash_words,
    output logic            valid_out,
    output b2w_vec_t        v_out,
    output b2w_word_t       nonce_out
);

    localparam int unsigned RND   = STEP / B2W_STEPS_PER_ROUND;
    localparam int unsigned LAYER = (STEP / 4) % 2;
    localparam int unsigned PHASE = STEP % 4;
    localparam int unsigned ROT   = (PHASE == 0) ? 32 :
                                    (PHASE == 1) ? 24 :
                                    (PHASE == 2) ? 16 : 63;

    logic      valid_reg;
    b2w_vec_t  v_reg;
    b2w_word_t nonce_reg;
    b2w_vec_t  v_next;

    logic [3:0][3:0]  tgt_p;
    logic [3:0][3:0]  tgt_q;
    logic [3:0][63:0] val_p;
    logic [3:0][63:0] val_q;

    // Per-lane arithmetic; column layer or diagonal layer index pattern
    for (genvar j = 0; j < 4; j++) begin : g_lane
        localparam int unsigned IA = j;
        localparam int unsigned IB = 4  + ((j + LAYER) % 4);
        localparam int unsigned IC = 8  + ((j + 2 * LAYER) % 4);
        localparam int unsigned ID = 12 + ((j + 3 * LAYER) % 4);

        b2w_word_t sum;
        b2w_word_t mixed;

        if (PHASE == 0 || PHASE == 2) begin : g_add_msg
            localparam logic [3:0] MIDX =
                b2w_sigma(4'(RND), 4'(8 * LAYER + 2 * j + PHASE / 2));
            b2w_word_t m_word;

            assign m_word = b2w_msg(MIDX, nonce_in, hash_words);
            // a += b + m; d = (d ^ a) >>> rot
            assign sum    = v_in[IA] + v_in[IB] + m_word;
            assign mixed  = v_in[ID] ^ sum;
            assign tgt_p[j] = 4'(IA);
            assign tgt_q[j] = 4'(ID);
        end else begin : g_add_d
            // c += d; b = (b ^ c) >>> rot
            assign sum    = v_in[IC] + v_in[ID];
            assign mixed  = v_in[IB] ^ sum;
            assign tgt_p[j] = 4'(IC);
            assign tgt_q[j] = 4'(IB);
        end

        assign val_p[j] = sum;
        assign val_q[j] = {mixed[ROT-1:0], mixed[63:ROT]};
    end

    // Merge lane results into the working vector
    always_comb
    begin
        v_next = v_in;
        for (int j = 0; j < 4; j++)
        begin
            v_next[tgt_p[j]] = val_p[j];
            v_next[tgt_q[j]] = val_q[j];
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg     <= v_next;
            nonce_reg <= nonce_in;
        end
    end

    assign valid_out = valid_reg;
    assign v_out     = v_reg;
    assign nonce_out = nonce_reg;

endmodule

`default_nettype wire

/* hdl/b2w_check.sv */
// Port-level checker for the BLAKE2b work check core, bound to the top level.
// Depends on b2w_pkg for register index codes.
`default_nettype none

module b2w_check
    import b2w_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [63:0]              out_digest,
    input wire logic                     out_meets,
    input wire logic                     cfg_we,
    input wire logic [B2W_CFG_IDX_W-1:0] cfg_index,
    input wire logic [63:0]              cfg_data
);

    logic [63:0] thresh_reg;

    // Shadow of the threshold as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_we && cfg_index == B2W_REG_THRESH)
        begin
            thresh_reg <= cfg_data;
        end
    end

    // A stalled result word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // Input is taken exactly when the output register can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("nonce ready does not follow output state");

    // Flag agrees with digest and threshold
    a_meets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_meets == (out_digest >= thresh_reg))
        else $error("threshold flag disagrees with digest");

endmodule

bind blake2b_work_threshold_check_core b2w_check u_b2w_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (nonce_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_digest (result_ch.digest),
    .out_meets  (result_ch.meets_threshold),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for blake2b_work_threshold_check_core: a directed table, then random
// nonce words under several flow-control modes, all checked against a local BLAKE2b model.
// Depends on b2w_pkg, b2w_if and the core RTL.

module testbench;
    import b2w_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned CORE_LATENCY  = 97;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned LONG_STALL    = 600;
    localparam int unsigned RAND_SEGMENTS = 10;
    localparam int unsigned SEG_NONCES    = 190;
    localparam int unsigned MAX_REPORTS   = 10;

    // Indexes past the last register; writes there must be dropped
    localparam logic [B2W_CFG_IDX_W-1:0] CFG_IDX_SPARE5 = 3'd5;
    localparam logic [B2W_CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
    localparam logic [B2W_CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    typedef logic [15:0][63:0] vec16_t;

    typedef struct packed {
        logic [63:0] nonce;
        logic [63:0] digest;
        logic        meets;
    } pow_result_t;

    typedef enum logic [2:0] {
        MODE_STEADY,
        MODE_SRC_GAPS,
        MODE_SINK_STALLS,
        MODE_BOTH,
        MODE_PRESSURE
    } flow_mode_e;

    typedef enum logic {ROW_WRITE, ROW_NONCE} row_kind_e;

    typedef struct packed {
        row_kind_e                  kind;
        logic [B2W_CFG_IDX_W-1:0]   idx;
        logic [63:0]                data;
        logic                       pinned;
        logic                       meets;
    } dir_row_t;

    // BLAKE2b IV and per-round message permutation, one hex digit per position
    localparam logic [0:7][63:0] BLAKE_IV = {
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [0:11][63:0] MSG_PERM = {
        64'h0123456789abcdef, 64'hea489fd61c02b753, 64'hb8c052fdae367194,
        64'h7931dcbe265a40f8, 64'h905724afe1bc683d, 64'h2c6a0b834d75fe19,
        64'hc51fed4a0763928b, 64'hdb7ec13950f4862a, 64'h6fe9b308c2d714a5,
        64'ha2847615fb9e3cd0, 64'h0123456789abcdef, 64'hea489fd61c02b753
    };

    // Directed table; meets is typed in only where it is obvious (threshold 0 or near max)
    localparam int unsigned DIR_ROWS = 36;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // reset config: zero hash words, zero threshold
        '{ROW_NONCE, '0,             64'h0,                 1'b1, 1'b1},
        '{ROW_NONCE, '0,             ALL_ONES,              1'b1, 1'b1},
        '{ROW_NONCE, '0,             64'h1,                 1'b1, 1'b1},
        '{ROW_NONCE, '0,             TOP_BIT,               1'b1, 1'b1},
        // max threshold
        '{ROW_WRITE, B2W_REG_THRESH, ALL_ONES,              1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h0,                 1'b1, 1'b0},
        '{ROW_NONCE, '0,             ALL_ONES,              1'b1, 1'b0},
        // all-ones block hash
        '{ROW_WRITE, B2W_REG_HASH0,  ALL_ONES,              1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH1,  ALL_ONES,              1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH2,  ALL_ONES,              1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH3,  ALL_ONES,              1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h0,                 1'b1, 1'b0},
        '{ROW_NONCE, '0,             ALL_ONES,              1'b1, 1'b0},
        '{ROW_NONCE, '0,             64'h5555_5555_5555_5555, 1'b0, 1'b0},
        // zero threshold: everything qualifies
        '{ROW_WRITE, B2W_REG_THRESH, 64'h0,                 1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1},
        // out-of-range indexes must not touch any register
        '{ROW_WRITE, CFG_IDX_SPARE5, 64'h0,                 1'b0, 1'b0},
        '{ROW_WRITE, CFG_IDX_SPARE6, 64'h0,                 1'b0, 1'b0},
        '{ROW_WRITE, CFG_IDX_SPARE7, 64'hffff_ffff_ffff_fff0, 1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h0123_4567_89ab_cdef, 1'b1, 1'b1},
        '{ROW_NONCE, '0,             64'h0,                 1'b1, 1'b1},
        // mid threshold
        '{ROW_WRITE, B2W_REG_THRESH, TOP_BIT,               1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h0,                 1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h1,                 1'b0, 1'b0},
        '{ROW_NONCE, '0,             ALL_ONES,              1'b0, 1'b0},
        // distinct hash words
        '{ROW_WRITE, B2W_REG_HASH0,  64'h0123_4567_89ab_cdef, 1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH1,  64'hfedc_ba98_7654_3210, 1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH2,  64'h0,                 1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_HASH3,  64'h1,                 1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_THRESH, 64'h1,                 1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h0,                 1'b0, 1'b0},
        '{ROW_NONCE, '0,             ALL_ONES,              1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h2,                 1'b0, 1'b0},
        '{ROW_WRITE, B2W_REG_THRESH, 64'hffff_ffff_ffff_fffe, 1'b0, 1'b0},
        '{ROW_NONCE, '0,             64'h3,                 1'b1, 1'b0},
        '{ROW_NONCE, '0,             64'hfedc_ba98_7654_3210, 1'b1, 1'b0}
    };

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [B2W_CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]              cfg_data  = '0;
    flow_mode_e               flow_mode = MODE_STEADY;

    // Predictor copy of the registers
    logic [3:0][63:0] model_hash   = '0;
    logic [63:0]      model_thresh = '0;

    pow_result_t   pending_results[$];
    logic [1:0]    pinned_meets[$];
    int unsigned   mismatches = 0;

    b2w_nonce_if  nonce_ch();
    b2w_result_if result_ch();

    blake2b_work_threshold_check_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .nonce_ch  (nonce_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] w, input int k);
        return (w >> k) | (w << (64 - k));
    endfunction

    // One G function on lanes a, b, c, d
    function automatic vec16_t g_mix(input vec16_t v_in, input int a, input int b,
                                     input int c, input int d,
                                     input logic [63:0] x, input logic [63:0] y);
        vec16_t v;
        v = v_in;
        v[a] = v[a] + v[b] + x;
        v[d] = rotr(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + y;
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 63);
        return v;
    endfunction

    // Single final-block compression of nonce plus hash words, 8-byte digest
    function automatic logic [63:0] blake_digest(input logic [63:0] nonce,
                                                 input logic [3:0][63:0] hw);
        vec16_t      m;
        vec16_t      v;
        logic [63:0] h0;
        logic [3:0]  s [16];
        int          r;
        int          j;
        h0 = BLAKE_IV[0] ^ 64'h0101_0008;
        m = '0;
        m[0] = nonce;
        for (j = 0; j < 4; j++)
            m[j + 1] = hw[j];
        for (j = 0; j < 8; j++)
        begin
            v[j]     = BLAKE_IV[j];
            v[j + 8] = BLAKE_IV[j];
        end
        v[0]  = h0;
        v[12] = v[12] ^ 64'd40;     // byte count
        v[14] = ~v[14];             // last block
        for (r = 0; r < 12; r++)
        begin
            for (j = 0; j < 16; j++)
                s[j] = MSG_PERM[r][60 - 4 * j +: 4];
            v = g_mix(v, 0, 4,  8, 12, m[s[0]],  m[s[1]]);
            v = g_mix(v, 1, 5,  9, 13, m[s[2]],  m[s[3]]);
            v = g_mix(v, 2, 6, 10, 14, m[s[4]],  m[s[5]]);
            v = g_mix(v, 3, 7, 11, 15, m[s[6]],  m[s[7]]);
            v = g_mix(v, 0, 5, 10, 15, m[s[8]],  m[s[9]]);
            v = g_mix(v, 1, 6, 11, 12, m[s[10]], m[s[11]]);
            v = g_mix(v, 2, 7,  8, 13, m[s[12]], m[s[13]]);
            v = g_mix(v, 3, 4,  9, 14, m[s[14]], m[s[15]]);
        end
        return h0 ^ v[0] ^ v[8];
    endfunction

    // Percent of cycles a side sits out in a given mode
    function automatic int unsigned gap_pct(input flow_mode_e mode, input bit sink_side);
        case (mode)
            MODE_SRC_GAPS:    return sink_side ? 0 : 77;
            MODE_SINK_STALLS: return sink_side ? 77 : 0;
            MODE_BOTH:        return 25;
            default:          return 0;
        endcase
    endfunction

    task automatic flag_mismatch(input bit orphan, input pow_result_t want,
                                 input pow_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            if (orphan)
                $display("unexpected result word: nonce=%h digest=%h meets=%b",
                         got.nonce, got.digest, got.meets);
            else
                $display("result mismatch: exp nonce=%h digest=%h meets=%b, got nonce=%h digest=%h meets=%b",
                         want.nonce, want.digest, want.meets, got.nonce, got.digest, got.meets);
        end
    endtask

    // Scoreboard: predict on nonce accept, compare on result accept, track register writes
    always @(posedge clk)
    begin : scoreboard
        pow_result_t want;
        pow_result_t got;
        logic [1:0]  pin;
        if (rst_n)
        begin
            if (nonce_ch.valid && nonce_ch.ready)
            begin
                want.nonce  = nonce_ch.nonce;
                want.digest = blake_digest(nonce_ch.nonce, model_hash);
                want.meets  = (want.digest >= model_thresh);
                if (pinned_meets.size() != 0)
                begin
                    pin = pinned_meets.pop_front();
                    if (pin[1])
                        want.meets = pin[0];
                end
                pending_results.push_back(want);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.nonce  = result_ch.nonce_out;
                got.digest = result_ch.digest;
                got.meets  = result_ch.meets_threshold;
                if (pending_results.size() == 0)
                    flag_mismatch(1'b1, got, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.nonce !== want.nonce || got.digest !== want.digest
                        || got.meets !== want.meets)
                        flag_mismatch(1'b0, want, got);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    B2W_REG_HASH0:  model_hash[0] <= cfg_data;
                    B2W_REG_HASH1:  model_hash[1] <= cfg_data;
                    B2W_REG_HASH2:  model_hash[2] <= cfg_data;
                    B2W_REG_HASH3:  model_hash[3] <= cfg_data;
                    B2W_REG_THRESH: model_thresh  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Result side: random stalls per mode, plus a long hold-off on entering pressure mode
    initial
    begin : sink_side
        int unsigned stall_left;
        flow_mode_e  seen_mode;
        stall_left = 0;
        seen_mode  = MODE_STEADY;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (flow_mode == MODE_PRESSURE && seen_mode != MODE_PRESSURE)
                stall_left = LONG_STALL;
            seen_mode = flow_mode;
            if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= gap_pct(flow_mode, 1'b1));
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Offer one nonce word, with random idle cycles ahead of it
    task automatic push_nonce(input logic [63:0] value);
        while ($urandom_range(99) < gap_pct(flow_mode, 1'b0))
        begin
            nonce_ch.valid <= 1'b0;
            nonce_ch.nonce <= rand64();
            @(posedge clk);
        end
        nonce_ch.valid <= 1'b1;
        nonce_ch.nonce <= value;
        @(posedge clk);
        while (!nonce_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [B2W_CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        nonce_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          i;
        int          seg;
        int          n;
        int          w;
        logic [63:0] word;
        nonce_ch.valid = 1'b0;
        nonce_ch.nonce = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            end
            else
            begin
                pinned_meets.push_back({DIR_TAB[i].pinned, DIR_TAB[i].meets});
                push_nonce(DIR_TAB[i].data);
            end
        end

        // Random segments, each with fresh registers and its own flow mode
        for (seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            drain_results();
            flow_mode <= flow_mode_e'(seg % 5);
            for (w = 0; w < 4; w++)
            begin
                case ($urandom_range(7))
                    0:       word = '0;
                    1:       word = ALL_ONES;
                    default: word = rand64();
                endcase
                write_reg(B2W_REG_HASH0 + w[2:0], word);
            end
            case ($urandom_range(5))
                0:       word = '0;
                1:       word = ALL_ONES;
                2:       word = TOP_BIT;
                default: word = rand64();
            endcase
            write_reg(B2W_REG_THRESH, word);
            if ($urandom_range(2) == 0)
                write_reg(CFG_IDX_SPARE5 + 3'($urandom_range(2)), rand64());
            for (n = 0; n < SEG_NONCES; n++)
            begin
                case ($urandom_range(15))
                    0:       word = '0;
                    1:       word = ALL_ONES;
                    2:       word = 64'd1 << $urandom_range(63);
                    default: word = rand64();
                endcase
                push_nonce(word);
            end
        end

        drain_results();
        repeat (2 * CORE_LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
